// ----- hdl/wgsr_pkg.sv -----
package wgsr_pkg;

    // Default sizes, handed to the top level parameters
    localparam int LINE_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    // Register field widths
    localparam int DELAY_BITS     = 12;
    localparam int COEF_BITS      = 18;
    localparam int ALPHA_BITS     = 16;
    localparam int FGAIN_BITS     = 16;
    localparam int DECAY_BITS     = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 12'd109;
    localparam logic [FGAIN_BITS-1:0] FGAIN_RESET = 16'd65470;
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = 32'hFFFF_FFFF;

    // Shortest loop delay that runs the string
    localparam logic [DELAY_BITS-1:0] MIN_DELAY = 12'd2;

    // Unity pole complement of the loop lowpass, Q1.16
    localparam logic [ALPHA_BITS:0] ALPHA_ONE = 17'd65536;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DELAY_LENGTH  = 3'd0,
        REG_THIRAN_COEF   = 3'd1,
        REG_LOOP_ALPHA    = 3'd2,
        REG_FEEDBACK_GAIN = 3'd3,
        REG_DAMPER_ACTIVE = 3'd4,
        REG_DAMPER_DECAY  = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHORT,
        ST_LOAD,
        ST_AP_MUL,
        ST_AP,
        ST_LPA_MUL,
        ST_LPB_MUL,
        ST_LP,
        ST_FG_MUL,
        ST_FG,
        ST_FB_MUL,
        ST_FB,
        ST_WRITE
    } wgsr_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AP,
        MUL_DMP,
        MUL_LPA,
        MUL_LPB,
        MUL_FG,
        MUL_FB
    } mul_op_t;

    typedef struct packed {
        logic    start;
        logic    load_delayed;
        logic    load_mid;
        mul_op_t mul_op;
        logic    upd_ap;
        logic    upd_gain;
        logic    upd_acc;
        logic    upd_lp;
        logic    upd_fb16;
        logic    upd_fb;
        logic    commit;
        logic    skip;
    } dp_cmd_t;

    typedef struct packed {
        logic short_delay;
    } dp_status_t;

endpackage

// ----- hdl/wgsr_if.sv -----
interface wgsr_in_if
    import wgsr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] excitation;
    logic                          block_last;

    modport source (output valid, output excitation, output block_last, input ready);
    modport sink   (input valid, input excitation, input block_last, output ready);
endinterface

interface wgsr_out_if
    import wgsr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] bridge_out;
    logic signed [SAMPLE_BITS-1:0] mid_out;
    logic                          block_last_out;

    modport source (output valid, output bridge_out, output mid_out, output block_last_out,
                    input ready);
    modport sink   (input valid, input bridge_out, input mid_out, input block_last_out,
                    output ready);
endinterface

// ----- hdl/wgsr_ram.sv -----
module wgsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/wgsr_ctrl.sv -----
module wgsr_ctrl
    import wgsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    wgsr_state_t state_reg;
    wgsr_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Hold state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one sample through the shared multiplier
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.short_delay ? ST_SHORT : ST_LOAD;
                end
            end
            ST_SHORT:
            begin
                if (out_free)
                begin
                    cmd.skip   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load_delayed = 1'b1;
                state_next       = ST_AP_MUL;
            end
            ST_AP_MUL:
            begin
                cmd.load_mid = 1'b1;
                cmd.mul_op   = MUL_AP;
                state_next   = ST_AP;
            end
            ST_AP:
            begin
                cmd.upd_ap = 1'b1;
                cmd.mul_op = MUL_DMP;
                state_next = ST_LPA_MUL;
            end
            ST_LPA_MUL:
            begin
                cmd.upd_gain = 1'b1;
                cmd.mul_op   = MUL_LPA;
                state_next   = ST_LPB_MUL;
            end
            ST_LPB_MUL:
            begin
                cmd.upd_acc = 1'b1;
                cmd.mul_op  = MUL_LPB;
                state_next  = ST_LP;
            end
            ST_LP:
            begin
                cmd.upd_lp = 1'b1;
                state_next = ST_FG_MUL;
            end
            ST_FG_MUL:
            begin
                cmd.mul_op = MUL_FG;
                state_next = ST_FG;
            end
            ST_FG:
            begin
                cmd.upd_fb16 = 1'b1;
                state_next   = ST_FB_MUL;
            end
            ST_FB_MUL:
            begin
                cmd.mul_op = MUL_FB;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                cmd.upd_fb = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Raise the result flag on a new result, drop it on transfer
    always_comb
    begin
        if (cmd.commit || cmd.skip)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("controller took a second sample while busy");

    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.commit, cmd.skip}))
        else $error("start and result events overlap");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.skip) |=> out_valid_reg)
        else $error("result not presented after completion");

endmodule

// ----- hdl/wgsr_dpath.sv -----
module wgsr_dpath
    import wgsr_pkg::*;
#(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     excitation,
    input  logic                              block_last,
    output logic signed [SAMPLE_BITS-1:0]     bridge_out,
    output logic signed [SAMPLE_BITS-1:0]     mid_out,
    output logic                              block_last_out,
    input  dp_cmd_t                           cmd,
    output dp_status_t                        status,
    output logic                              ram_we,
    output logic [$clog2(LINE_DEPTH)-1:0]     ram_waddr,
    output logic [SAMPLE_BITS-1:0]            ram_wdata,
    output logic [$clog2(LINE_DEPTH)-1:0]     ram_raddr,
    input  logic [SAMPLE_BITS-1:0]            ram_rdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int MW = (SB + 1 > 33) ? SB + 1 : 33;
    localparam int MB = 33;
    localparam int PW = MW + MB;

    localparam logic [31:0]          MAX_DELAY = 32'(LINE_DEPTH - 1);
    localparam logic [AW-1:0]        LAST_POS  = AW'(LINE_DEPTH - 1);
    localparam logic signed [PW-1:0] HALF16    = PW'(64'sd32768);
    localparam logic signed [PW-1:0] HALF32    = PW'(64'sd2147483648);
    localparam logic signed [PW:0]   SMAX      = (PW+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW:0]   SMIN      = -SMAX - (PW+1)'(64'sd1);

    function automatic logic signed [SB-1:0] sat_s(input logic signed [PW:0] v);
        logic signed [SB-1:0] r;
        begin
            if (v > SMAX)
            begin
                r = SB'(SMAX);
            end
            else if (v < SMIN)
            begin
                r = SB'(SMIN);
            end
            else
            begin
                r = SB'(v);
            end
            return r;
        end
    endfunction

    function automatic logic [AW-1:0] back_ptr(input logic [AW-1:0] p, input logic [AW-1:0] d);
        logic [AW:0] w;
        begin
            w = {1'b0, p} + (AW+1)'(LINE_DEPTH) - {1'b0, d};
            if (p >= d)
            begin
                w = {1'b0, p - d};
            end
            return w[AW-1:0];
        end
    endfunction

    // Configuration registers
    logic [DELAY_BITS-1:0]        dl_reg;
    logic signed [COEF_BITS-1:0]  coef_reg;
    logic [ALPHA_BITS-1:0]        alpha_reg;
    logic [FGAIN_BITS-1:0]        fg_reg;
    logic                         dmp_act_reg;
    logic [DECAY_BITS-1:0]        decay_reg;

    // Loop state
    logic                         gain_hi_reg;
    logic [31:0]                  gain_lo_reg;
    logic [AW-1:0]                wp_reg;
    logic                         wrapped_reg;
    logic signed [SB-1:0]         prev_in_reg;
    logic signed [SB-1:0]         prev_out_reg;
    logic signed [SB-1:0]         lp_state_reg;

    // Per-sample working registers
    logic signed [SB-1:0]         exc_reg;
    logic                         last_reg;
    logic                         rd_ok_reg;
    logic signed [SB-1:0]         delayed_reg;
    logic signed [SB-1:0]         mid_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [PW-1:0]         acc_reg;
    logic signed [SB:0]           fb16_reg;
    logic signed [SB-1:0]         fb_reg;
    logic signed [SB-1:0]         bridge_reg;
    logic signed [SB-1:0]         mid_out_reg;
    logic                         last_out_reg;

    logic [AW-1:0]                dl_eff;
    logic [AW-1:0]                rp;
    logic [AW-1:0]                mp;
    logic [AW-1:0]                raddr;
    logic                         rd_ok_next;
    logic signed [SB-1:0]         rd_sample;
    logic signed [MW-1:0]         mul_a;
    logic signed [MB-1:0]         mul_b;
    logic signed [PW-1:0]         prod_next;
    logic signed [PW-1:0]         ap_round;
    logic signed [SB-1:0]         ap_next;
    logic signed [PW:0]           lp_wide;
    logic signed [SB-1:0]         lp_next;
    logic signed [PW-1:0]         g_sum;
    logic [31:0]                  gain_next;
    logic signed [PW-1:0]         fg_sum;
    logic signed [PW-1:0]         fb_round;
    logic signed [SB-1:0]         fb_next;
    logic signed [SB:0]           wsum;
    logic signed [SB-1:0]         wsat;
    logic [AW-1:0]                wp_next;

    // Clamp the delay and locate the read taps
    assign dl_eff = (32'(dl_reg) > MAX_DELAY) ? LAST_POS : AW'(dl_reg);
    assign rp     = back_ptr(wp_reg, dl_eff);
    assign mp     = back_ptr(wp_reg, dl_eff >> 1);
    assign raddr  = cmd.start ? rp : mp;

    // An entry is written once the head has passed it
    assign rd_ok_next = wrapped_reg || (raddr < wp_reg);
    assign rd_sample  = rd_ok_reg ? signed'(ram_rdata) : '0;

    assign status.short_delay = dl_reg < MIN_DELAY;

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_AP:
            begin
                mul_a = MW'((SB+1)'(delayed_reg) - (SB+1)'(prev_out_reg));
                mul_b = MB'(coef_reg);
            end
            MUL_DMP:
            begin
                mul_a = MW'({1'b0, gain_lo_reg});
                mul_b = MB'({1'b0, decay_reg});
            end
            MUL_LPA:
            begin
                mul_a = MW'(prev_out_reg);
                mul_b = MB'(ALPHA_ONE - {1'b0, alpha_reg});
            end
            MUL_LPB:
            begin
                mul_a = MW'(lp_state_reg);
                mul_b = MB'(alpha_reg);
            end
            MUL_FG:
            begin
                mul_a = MW'(lp_state_reg);
                mul_b = MB'(fg_reg);
            end
            MUL_FB:
            begin
                mul_a = MW'(fb16_reg);
                mul_b = MB'({1'b0, gain_lo_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round and saturate the products
    assign ap_round  = (prod_reg + HALF16) >>> 16;
    assign ap_next   = sat_s((PW+1)'(ap_round) + (PW+1)'(prev_in_reg));
    assign lp_wide   = ((PW+1)'(acc_reg) + (PW+1)'(prod_reg) + (PW+1)'(HALF16)) >>> 16;
    assign lp_next   = sat_s(lp_wide);
    assign g_sum     = prod_reg + HALF32;
    assign gain_next = gain_hi_reg ? decay_reg : g_sum[63:32];
    assign fg_sum    = prod_reg + HALF16;
    assign fb_round  = (prod_reg + HALF32) >>> 32;
    assign fb_next   = gain_hi_reg ? sat_s((PW+1)'(fb16_reg)) : sat_s((PW+1)'(fb_round));
    assign wsum      = (SB+1)'(exc_reg) + (SB+1)'(fb_reg);
    assign wsat      = sat_s((PW+1)'(wsum));
    assign wp_next   = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;

    // Configuration, damper and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg       <= DELAY_RESET;
            coef_reg     <= '0;
            alpha_reg    <= '0;
            fg_reg       <= FGAIN_RESET;
            dmp_act_reg  <= 1'b0;
            decay_reg    <= DECAY_RESET;
            gain_hi_reg  <= 1'b1;
            gain_lo_reg  <= '0;
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
            lp_state_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DELAY_LENGTH:  dl_reg    <= cfg_data[DELAY_BITS-1:0];
                    REG_THIRAN_COEF:   coef_reg  <= signed'(cfg_data[COEF_BITS-1:0]);
                    REG_LOOP_ALPHA:    alpha_reg <= cfg_data[ALPHA_BITS-1:0];
                    REG_FEEDBACK_GAIN: fg_reg    <= cfg_data[FGAIN_BITS-1:0];
                    REG_DAMPER_ACTIVE:
                    begin
                        dmp_act_reg <= cfg_data[0];
                        if (!cfg_data[0])
                        begin
                            gain_hi_reg <= 1'b1;
                            gain_lo_reg <= '0;
                        end
                    end
                    REG_DAMPER_DECAY:  decay_reg <= cfg_data[DECAY_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.upd_gain && dmp_act_reg)
            begin
                gain_hi_reg <= 1'b0;
                gain_lo_reg <= gain_next;
            end
            if (cmd.upd_ap)
            begin
                prev_in_reg  <= delayed_reg;
                prev_out_reg <= ap_next;
            end
            if (cmd.upd_lp)
            begin
                lp_state_reg <= lp_next;
            end
            if (cmd.commit)
            begin
                wp_reg <= wp_next;
                if (wp_reg == LAST_POS)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        rd_ok_reg <= rd_ok_next;
        if (cmd.start)
        begin
            exc_reg  <= excitation;
            last_reg <= block_last;
        end
        if (cmd.load_delayed)
        begin
            delayed_reg <= rd_sample;
        end
        if (cmd.load_mid)
        begin
            mid_reg <= rd_sample;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.upd_acc)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.upd_fb16)
        begin
            fb16_reg <= fg_sum[SB+16:16];
        end
        if (cmd.upd_fb)
        begin
            fb_reg <= fb_next;
        end
        if (cmd.commit)
        begin
            bridge_reg   <= fb_reg;
            mid_out_reg  <= mid_reg;
            last_out_reg <= last_reg;
        end
        else if (cmd.skip)
        begin
            bridge_reg   <= '0;
            mid_out_reg  <= '0;
            last_out_reg <= last_reg;
        end
    end

    assign ram_we         = cmd.commit;
    assign ram_waddr      = wp_reg;
    assign ram_wdata      = wsat;
    assign ram_raddr      = raddr;
    assign bridge_out     = bridge_reg;
    assign mid_out        = mid_out_reg;
    assign block_last_out = last_out_reg;

    a_gain_unity_form: assert property (@(posedge clk) disable iff (!rst_n)
        gain_hi_reg |-> (gain_lo_reg == '0))
        else $error("damper gain above one");

endmodule

// ----- hdl/waveguide_string_resonator.sv -----
// Channel  Dir  Transfer when          Payload
// excite   in   excite.valid & ready   excitation (Q3.20), block_last
// pickup   out  pickup.valid & ready   bridge_out, mid_out (Q3.20), block_last_out
// cfg      in   cfg_wr_en              cfg_index selects register, cfg_data value
//
// Samples do not overlap: the next is accepted only once the current result is
// complete; a single shared 33x33 multiplier serves six products in sequence.
// A delay_length below two gives a zero result.
// Reset restores configuration and loop state; the delay line needs no
// clearing pass, since entries the head has not yet reached read as zero.
// A stalled pickup holds the next sample in its final step until the result moves.
module waveguide_string_resonator
    import wgsr_pkg::*;
#(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    wgsr_in_if.sink                   excite,
    wgsr_out_if.source                pickup
);

    localparam int AW = $clog2(LINE_DEPTH);

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // Sequence control
    wgsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (excite.valid),
        .in_ready  (excite.ready),
        .out_valid (pickup.valid),
        .out_ready (pickup.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Filter arithmetic and loop state
    wgsr_dpath #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .excitation     (excite.excitation),
        .block_last     (excite.block_last),
        .bridge_out     (pickup.bridge_out),
        .mid_out        (pickup.mid_out),
        .block_last_out (pickup.block_last_out),
        .cmd            (cmd),
        .status         (status),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    // Circular delay line
    wgsr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- sim/tb_waveguide_string_resonator.sv -----
// Tracks the string loop in software and checks every pickup transfer against it.
class pickup_scoreboard;
    localparam int DEPTH       = wgsr_pkg::LINE_DEPTH_DEF;
    localparam int SB          = wgsr_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_PRINTED = 40;
    localparam longint SAMPLE_TOP    = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SAMPLE_BOTTOM = -(64'sd1 <<< (SB - 1));
    localparam longint GAIN_UNITY    = 64'sd1 <<< 32;

    typedef struct {
        logic signed [SB-1:0] bridge;
        logic signed [SB-1:0] mid;
        logic                 last;
    } pickup_t;

    // Register copies
    longint delay_len;
    longint coef;
    longint alpha;
    longint fgain;
    bit     damp_on;
    longint decay;

    // Loop state
    longint string_line[DEPTH];
    longint head;
    longint ap_in;
    longint ap_out;
    longint lp_state;
    longint gain;

    pickup_t pickup_expected[$];
    int      errors;

    function new();
        delay_len = longint'(wgsr_pkg::DELAY_RESET);
        coef      = 0;
        alpha     = 0;
        fgain     = longint'(wgsr_pkg::FGAIN_RESET);
        damp_on   = 1'b0;
        decay     = longint'(wgsr_pkg::DECAY_RESET);
        foreach (string_line[i])
            string_line[i] = 0;
        head     = 0;
        ap_in    = 0;
        ap_out   = 0;
        lp_state = 0;
        gain     = GAIN_UNITY;
        errors   = 0;
    endfunction

    function longint saturate(longint v);
        if (v > SAMPLE_TOP)
            return SAMPLE_TOP;
        if (v < SAMPLE_BOTTOM)
            return SAMPLE_BOTTOM;
        return v;
    endfunction

    // Add half an LSB, then shift right arithmetically
    function longint round_off(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function void write_reg(logic [wgsr_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [wgsr_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            wgsr_pkg::REG_DELAY_LENGTH:
                delay_len = longint'(data[wgsr_pkg::DELAY_BITS-1:0]);
            wgsr_pkg::REG_THIRAN_COEF:
                coef = longint'($signed(data[wgsr_pkg::COEF_BITS-1:0]));
            wgsr_pkg::REG_LOOP_ALPHA:
                alpha = longint'(data[wgsr_pkg::ALPHA_BITS-1:0]);
            wgsr_pkg::REG_FEEDBACK_GAIN:
                fgain = longint'(data[wgsr_pkg::FGAIN_BITS-1:0]);
            wgsr_pkg::REG_DAMPER_ACTIVE:
            begin
                damp_on = data[0];
                // releasing the damper puts the gain back to one
                if (!data[0])
                    gain = GAIN_UNITY;
            end
            wgsr_pkg::REG_DAMPER_DECAY:
                decay = longint'(data[wgsr_pkg::DECAY_BITS-1:0]);
            default: ;
        endcase
    endfunction

    // Run one excitation sample around the loop and queue the pickup it yields
    function void note_sample(logic signed [SB-1:0] exc, logic last);
        pickup_t     want;
        longint      span;
        longint      tap_pos;
        longint      tapped;
        longint      ap;
        longint      lp;
        longint      fb;
        longint      mid_pos;
        logic [65:0] gprod;
        want.bridge = '0;
        want.mid    = '0;
        want.last   = last;
        // a too-short loop leaves the string untouched
        if (delay_len >= longint'(wgsr_pkg::MIN_DELAY))
        begin
            span    = (delay_len > DEPTH - 1) ? DEPTH - 1 : delay_len;
            tap_pos = (head + DEPTH - span) % DEPTH;
            tapped  = string_line[tap_pos];

            ap     = saturate(round_off(coef * (tapped - ap_out), 16) + ap_in);
            ap_in  = tapped;
            ap_out = ap;

            lp = saturate(round_off((longint'(wgsr_pkg::ALPHA_ONE) - alpha) * ap
                                    + alpha * lp_state, 16));
            lp_state = lp;

            if (damp_on)
            begin
                gprod = 66'(gain) * 66'(decay) + (66'd1 << 31);
                gain  = longint'(gprod >> 32);
            end

            fb = saturate(round_off(round_off(fgain * lp, 16) * gain, 32));
            string_line[head] = saturate(longint'(exc) + fb);

            mid_pos     = (head + DEPTH - span / 2) % DEPTH;
            want.bridge = fb[SB-1:0];
            want.mid    = string_line[mid_pos][SB-1:0];
            head        = (head + 1) % DEPTH;
        end
        pickup_expected.push_back(want);
    endfunction

    function int pending();
        return pickup_expected.size();
    endfunction

    task report(string msg);
        if (errors < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic signed [SB-1:0] bridge, logic signed [SB-1:0] mid, logic last);
        pickup_t want;
        if (pickup_expected.size() == 0)
        begin
            report($sformatf("pickup transfer with no sample outstanding: bridge %0d mid %0d",
                             bridge, mid));
            return;
        end
        want = pickup_expected.pop_front();
        if (bridge !== want.bridge)
            report($sformatf("bridge_out got %0d want %0d", bridge, want.bridge));
        if (mid !== want.mid)
            report($sformatf("mid_out got %0d want %0d", mid, want.mid));
        if (last !== want.last)
            report($sformatf("block_last_out got %0b want %0b", last, want.last));
    endtask
endclass

module tb_waveguide_string_resonator;
    timeunit 1ns;
    timeprecision 1ps;
    import wgsr_pkg::*;

    localparam int SB              = SAMPLE_BITS_DEF;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASE_ITEMS     = 85;
    localparam int HOLD_OFF_CYCLES = 300;

    // Indexes past the last register
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    wgsr_in_if  #(.SAMPLE_BITS(SB)) excite_ch ();
    wgsr_out_if #(.SAMPLE_BITS(SB)) pickup_ch ();

    pickup_scoreboard sb;

    int          recv_stall_pct   = 0;
    int          hold_cycles_left = 0;
    int          burst_left       = 0;
    int unsigned cycle_count      = 0;
    int          send_idle_by_mode[4]  = '{0, 62, 0, 27};
    int          recv_stall_by_mode[4] = '{0, 0, 62, 27};

    waveguide_string_resonator #(
        .LINE_DEPTH  (LINE_DEPTH_DEF),
        .SAMPLE_BITS (SB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .excite    (excite_ch),
        .pickup    (pickup_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a run that reaches the cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("waveguide_string_resonator verification failed");
            $finish;
        end
    end

    // Pickup side: stall at random, or hold off entirely while a hold-off is pending
    initial
    begin
        pickup_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_left > 0)
            begin
                pickup_ch.ready <= 1'b0;
                hold_cycles_left--;
            end
            else
                pickup_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every pickup transfer
    always @(posedge clk)
    begin
        if (rst_n && pickup_ch.valid && pickup_ch.ready)
            sb.check_result(pickup_ch.bridge_out, pickup_ch.mid_out, pickup_ch.block_last_out);
    end

    // Offer one sample, hold it until the transfer, then note it
    task automatic send_sample(logic signed [SB-1:0] sample, logic last);
        excite_ch.valid      <= 1'b1;
        excite_ch.excitation <= sample;
        excite_ch.block_last <= last;
        @(posedge clk);
        while (!excite_ch.ready)
            @(posedge clk);
        sb.note_sample(sample, last);
    endtask

    // Drop valid and wait until every queued pickup has come out
    task automatic drain_string();
        excite_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Mostly plucks: a short noise burst, then silence so the string rings
    function automatic logic signed [SB-1:0] next_excitation();
        logic [31:0] r;
        r = $urandom;
        if (burst_left > 0)
        begin
            burst_left--;
            return $signed(r[SB-1:0]) >>> $urandom_range(4);
        end
        case ($urandom_range(9))
            0, 1: return r[SB-1:0];
            2:
            begin
                burst_left = $urandom_range(24, 1);
                return r[SB-1:0];
            end
            default: return '0;
        endcase
    endfunction

    // Pick a fresh tuning, extremes included, with junk above each register's width
    task automatic retune_string();
        logic [31:0]           junk;
        logic [DELAY_BITS-1:0] d;
        logic [COEF_BITS-1:0]  c;
        logic [ALPHA_BITS-1:0] a;
        logic [FGAIN_BITS-1:0] g;
        logic [DECAY_BITS-1:0] k;
        junk = $urandom;
        case ($urandom_range(9))
            0:       d = DELAY_BITS'($urandom_range(1));
            1:       d = {DELAY_BITS{1'b1}};
            2:       d = DELAY_BITS'($urandom_range(600, 41));
            default: d = DELAY_BITS'($urandom_range(40, 2));
        endcase
        case ($urandom_range(7))
            0:       c = COEF_MAX;
            1:       c = COEF_MIN;
            default: c = COEF_BITS'($urandom_range(116000) - 58000);
        endcase
        case ($urandom_range(7))
            0:       a = '0;
            1:       a = '1;
            default: a = ALPHA_BITS'($urandom_range(58982));
        endcase
        case ($urandom_range(7))
            0:       g = '1;
            1:       g = '0;
            default: g = FGAIN_BITS'($urandom_range(65535, 60000));
        endcase
        case ($urandom_range(7))
            0:       k = '0;
            1:       k = '1;
            default: k = 32'hFFFF_FFFF - $urandom_range(2000000);
        endcase
        write_reg(REG_DELAY_LENGTH, {junk[31:DELAY_BITS], d});
        write_reg(REG_THIRAN_COEF, {junk[31:COEF_BITS], c});
        write_reg(REG_LOOP_ALPHA, {junk[31:ALPHA_BITS], a});
        write_reg(REG_FEEDBACK_GAIN, {junk[31:FGAIN_BITS], g});
        write_reg(REG_DAMPER_DECAY, k);
        write_reg(REG_DAMPER_ACTIVE, {junk[31:1], 1'($urandom_range(1))});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int items, int idle_pct, int stall_pct);
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                excite_ch.valid <= 1'b0;
                @(posedge clk);
            end
            send_sample(next_excitation(), $urandom_range(15) == 0);
        end
        drain_string();
    endtask

    initial
    begin
        sb = new();
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        excite_ch.valid      = 1'b0;
        excite_ch.excitation = '0;
        excite_ch.block_last = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset tuning: excitation extremes
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample(SB'(-1), 1'b0);
        send_sample(SB'(1), 1'b1);
        drain_string();

        // Shortest loop, full gain and the largest allpass coefficient: drive into saturation
        write_reg(REG_DELAY_LENGTH, CFG_DATA_BITS'(MIN_DELAY));
        write_reg(REG_THIRAN_COEF, CFG_DATA_BITS'(COEF_MAX));
        write_reg(REG_LOOP_ALPHA, '0);
        write_reg(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
        write_reg(REG_DAMPER_ACTIVE, '0);
        cfg_wr_en <= 1'b0;
        repeat (4) send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        drain_string();

        // Delay too short to run the string
        write_reg(REG_DELAY_LENGTH, '0);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        drain_string();
        write_reg(REG_DELAY_LENGTH, 32'hFFFF_F001);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b1);
        drain_string();

        // Most negative coefficient, alpha at its largest, damper on at half decay
        write_reg(REG_DELAY_LENGTH, 3);
        write_reg(REG_THIRAN_COEF, {{(CFG_DATA_BITS-COEF_BITS){1'b1}}, COEF_MIN});
        write_reg(REG_LOOP_ALPHA, 32'hFFFF_FFFF);
        write_reg(REG_DAMPER_DECAY, 32'h8000_0000);
        write_reg(REG_DAMPER_ACTIVE, 1);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);
        drain_string();

        // Re-enable keeps the decayed gain; spare indexes do nothing
        write_reg(REG_DAMPER_ACTIVE, 1);
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h0000_0000);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        drain_string();

        // Release restores unity gain; zero decay then silences the loop
        write_reg(REG_DAMPER_ACTIVE, 0);
        write_reg(REG_DAMPER_DECAY, '0);
        write_reg(REG_FEEDBACK_GAIN, '0);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b0);
        drain_string();
        write_reg(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
        write_reg(REG_DAMPER_ACTIVE, 1);
        cfg_wr_en <= 1'b0;
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        drain_string();

        // Random plucks over every idling mode, twice; one long pickup hold-off
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int mode = 0; mode < 4; mode++)
            begin
                retune_string();
                if (pass == 1 && mode == 0)
                    hold_cycles_left = HOLD_OFF_CYCLES;
                run_phase(PHASE_ITEMS, send_idle_by_mode[mode], recv_stall_by_mode[mode]);
            end
        end

        // Let any stray pickup show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("waveguide_string_resonator verification clean");
        else
            $display("waveguide_string_resonator verification failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/wgsr_pkg.sv
hdl/wgsr_if.sv
hdl/wgsr_ram.sv
hdl/wgsr_ctrl.sv
hdl/wgsr_dpath.sv
hdl/waveguide_string_resonator.sv
sim/tb_waveguide_string_resonator.sv
